// ----- rtl/core/cvp_pkg.sv -----
// shared types, constants and angle table for the camera view pipeline
`timescale 1ns / 1ps
package cvp_pkg;

	localparam int CORDIC_STAGES = 14;
	localparam int STG_W = $clog2(CORDIC_STAGES + 1);

	localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
	localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
	localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
	localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [33:0] z;
		logic               neg;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]       ln;
		logic [2:0][31:0]  pos;
	} cell_t;

	// atan(2^-i) in q.28
	function automatic logic signed [33:0] atan_q28(input logic [STG_W-1:0] i);
		logic signed [33:0] a;
		unique case (5'(i))
			5'd0:  a = 34'sd210828714;
			5'd1:  a = 34'sd124459457;
			5'd2:  a = 34'sd65760959;
			5'd3:  a = 34'sd33381290;
			5'd4:  a = 34'sd16755422;
			5'd5:  a = 34'sd8385879;
			5'd6:  a = 34'sd4193963;
			5'd7:  a = 34'sd2097109;
			5'd8:  a = 34'sd1048571;
			5'd9:  a = 34'sd524287;
			default: a = 34'sd1 <<< (28 - 32'(i));
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/core/cvp_if.sv -----
// pose and view channel interfaces
`timescale 1ns / 1ps
interface cvp_pose_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] angle_x;
	logic signed [15:0] angle_y;
	logic signed [15:0] angle_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	modport source(output valid, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z,
		input ready);
	modport sink(input valid, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface cvp_view_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [31:0] tr_x, tr_y, tr_z;
	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		tr_x, tr_y, tr_z, input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		tr_x, tr_y, tr_z, output ready);
endinterface

// ----- rtl/core/cvp_fold.sv -----
// angle range reduction into [-pi/2, pi/2] and cordic seed register
`timescale 1ns / 1ps
module cvp_fold (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  logic [2:0][15:0]    ang,
	input  logic [2:0][31:0]    pos,
	output logic                vld_q,
	output cvp_pkg::cell_t      cell_q
);
	cvp_pkg::cell_t seed;

	always_comb begin
		logic signed [33:0] z;
		seed.pos = pos;
		for (int k = 0; k < 3; k++) begin
			z = {{2{ang[k][15]}}, ang[k], 16'h0000};
			if (z > cvp_pkg::Q28_PI) z = z - cvp_pkg::Q28_TWO_PI;
			else if (z < -cvp_pkg::Q28_PI) z = z + cvp_pkg::Q28_TWO_PI;
			seed.ln[k].neg = 1'b0;
			if (z > cvp_pkg::Q28_HALF_PI) begin
				z = z - cvp_pkg::Q28_PI;
				seed.ln[k].neg = 1'b1;
			end else if (z < -cvp_pkg::Q28_HALF_PI) begin
				z = z + cvp_pkg::Q28_PI;
				seed.ln[k].neg = 1'b1;
			end
			seed.ln[k].x = cvp_pkg::Q28_GAIN;
			seed.ln[k].y = 32'sd0;
			seed.ln[k].z = z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld;
	end

	always_ff @(posedge clk) begin
		if (en) cell_q <= seed;
	end
endmodule

// ----- rtl/core/cvp_cell.sv -----
// one cordic micro-rotation for all three angles
`timescale 1ns / 1ps
module cvp_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [cvp_pkg::STG_W-1:0]  stage,
	input  logic                       vld,
	input  cvp_pkg::cell_t             din,
	output logic                       vld_q,
	output cvp_pkg::cell_t             cell_q
);
	cvp_pkg::cell_t nxt;
	logic signed [33:0] a;

	assign a = cvp_pkg::atan_q28(stage);

	always_comb begin
		logic signed [31:0] xs, ys;
		nxt = din;
		for (int k = 0; k < 3; k++) begin
			xs = din.ln[k].x >>> stage;
			ys = din.ln[k].y >>> stage;
			if (!din.ln[k].z[33]) begin
				nxt.ln[k].x = din.ln[k].x - ys;
				nxt.ln[k].y = din.ln[k].y + xs;
				nxt.ln[k].z = din.ln[k].z - a;
			end else begin
				nxt.ln[k].x = din.ln[k].x + ys;
				nxt.ln[k].y = din.ln[k].y - xs;
				nxt.ln[k].z = din.ln[k].z + a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld;
	end

	always_ff @(posedge clk) begin
		if (en) cell_q <= nxt;
	end
endmodule

// ----- rtl/core/cvp_matrix.sv -----
// sine/cosine rounding, rotation products and view translation
`timescale 1ns / 1ps
module cvp_matrix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  cvp_pkg::cell_t      din,
	output logic                vld_s5,
	output logic [2:0][2:0][15:0] m_s5,
	output logic [2:0][31:0]    tr_s5
);
	function automatic logic signed [15:0] rnd14(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = ($signed({v[31], v}) + 33'sd8192) >>> 14;
		if (t > 33'sd16384) return 16'sd16384;
		if (t < -33'sd16384) return -16'sd16384;
		return t[15:0];
	endfunction

	function automatic logic signed [15:0] rnd28(input logic signed [47:0] v);
		logic signed [47:0] t;
		t = (v + 48'sd134217728) >>> 28;
		if (t > 48'sd16384) return 16'sd16384;
		if (t < -48'sd16384) return -16'sd16384;
		return t[15:0];
	endfunction

	logic [4:0] vld_q;
	// s1: sin/cos per axis, order sx cx sy cy sz cz
	logic signed [15:0] sc_s1 [6];
	logic [2:0][31:0]   pos_s1, pos_s2, pos_s3, pos_s4;
	logic signed [31:0] czcy_s2, szcx_s2, czsy_s2, szsx_s2, szcy_s2;
	logic signed [31:0] czcx_s2, szsy_s2, czsx_s2, cysx_s2, cycx_s2;
	logic signed [15:0] sx_s2, cx_s2, sy_s2;
	logic [2:0][2:0][15:0] m_s3, m_s4;
	logic signed [47:0] pr_s4 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[3:0], vld};
	end
	assign vld_s5 = vld_q[4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sc_s1[2*k]   <= rnd14(din.ln[k].neg ? -din.ln[k].y : din.ln[k].y);
				sc_s1[2*k+1] <= rnd14(din.ln[k].neg ? -din.ln[k].x : din.ln[k].x);
			end
			pos_s1 <= din.pos;

			czcy_s2 <= sc_s1[5] * sc_s1[3];
			szcx_s2 <= sc_s1[4] * sc_s1[1];
			czsy_s2 <= sc_s1[5] * sc_s1[2];
			szsx_s2 <= sc_s1[4] * sc_s1[0];
			szcy_s2 <= sc_s1[4] * sc_s1[3];
			czcx_s2 <= sc_s1[5] * sc_s1[1];
			szsy_s2 <= sc_s1[4] * sc_s1[2];
			czsx_s2 <= sc_s1[5] * sc_s1[0];
			cysx_s2 <= sc_s1[3] * sc_s1[0];
			cycx_s2 <= sc_s1[3] * sc_s1[1];
			sx_s2   <= sc_s1[0];
			cx_s2   <= sc_s1[1];
			sy_s2   <= sc_s1[2];
			pos_s2  <= pos_s1;

			// m[i][j] = R[j][i]
			m_s3[0][0] <= rnd28(48'(czcy_s2) <<< 14);
			m_s3[1][0] <= rnd28(-(48'(szcx_s2) <<< 14) + 48'(czsy_s2) * 48'(sx_s2));
			m_s3[2][0] <= rnd28((48'(szsx_s2) <<< 14) + 48'(czsy_s2) * 48'(cx_s2));
			m_s3[0][1] <= rnd28(48'(szcy_s2) <<< 14);
			m_s3[1][1] <= rnd28((48'(czcx_s2) <<< 14) + 48'(szsy_s2) * 48'(sx_s2));
			m_s3[2][1] <= rnd28(-(48'(czsx_s2) <<< 14) + 48'(szsy_s2) * 48'(cx_s2));
			m_s3[0][2] <= rnd28(-(48'(sy_s2) <<< 28));
			m_s3[1][2] <= rnd28(48'(cysx_s2) <<< 14);
			m_s3[2][2] <= rnd28(48'(cycx_s2) <<< 14);
			pos_s3 <= pos_s2;

			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					pr_s4[i][k] <= 48'($signed(m_s3[i][k])) * 48'($signed(pos_s3[k]));
			m_s4 <= m_s3;
			pos_s4 <= pos_s3;

			m_s5 <= m_s4;
			for (int i = 0; i < 3; i++) begin
				logic signed [49:0] acc;
				acc = -(50'(pr_s4[i][0]) + 50'(pr_s4[i][1]) + 50'(pr_s4[i][2]));
				acc = (acc + 50'sd8192) >>> 14;
				if (acc > 50'sd2147483647) tr_s5[i] <= 32'h7fff_ffff;
				else if (acc < -50'sd2147483648) tr_s5[i] <= 32'h8000_0000;
				else tr_s5[i] <= acc[31:0];
			end
		end
	end
endmodule

// ----- rtl/core/camera_view_from_pose.sv -----
// view matrix from camera pose: fold, cordic cell chain, matrix pipeline
// pipeline registers from pose word to view word: 1 fold, 14 cordic cells, 5 matrix
// throughput: one word per cycle; the whole pipeline holds while a view word waits
// ready follows the output register only, so a pose is taken whenever it can advance
// reset: arst_n clears all stage valid bits asynchronously; data registers are not reset
`timescale 1ns / 1ps
module camera_view_from_pose (
	input  logic        clk,
	input  logic        arst_n,
	cvp_pose_if.sink    pose,
	cvp_view_if.source  view
);
	localparam int N = cvp_pkg::CORDIC_STAGES;

	logic en;
	logic           vld_c [N+1];
	cvp_pkg::cell_t cell_c [N+1];
	logic [2:0][2:0][15:0] m;
	logic [2:0][31:0] tr;

	assign en = !view.valid || view.ready;
	assign pose.ready = en;

	cvp_fold u_fold (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(pose.valid),
		.ang({pose.angle_z, pose.angle_y, pose.angle_x}),
		.pos({pose.pos_z, pose.pos_y, pose.pos_x}),
		.vld_q(vld_c[0]), .cell_q(cell_c[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_cell
		cvp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.stage(cvp_pkg::STG_W'(g)),
			.vld(vld_c[g]), .din(cell_c[g]),
			.vld_q(vld_c[g+1]), .cell_q(cell_c[g+1])
		);
	end

	cvp_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(vld_c[N]), .din(cell_c[N]),
		.vld_s5(view.valid), .m_s5(m), .tr_s5(tr)
	);

	assign view.m00 = m[0][0];
	assign view.m01 = m[0][1];
	assign view.m02 = m[0][2];
	assign view.m10 = m[1][0];
	assign view.m11 = m[1][1];
	assign view.m12 = m[1][2];
	assign view.m20 = m[2][0];
	assign view.m21 = m[2][1];
	assign view.m22 = m[2][2];
	assign view.tr_x = tr[0];
	assign view.tr_y = tr[1];
	assign view.tr_z = tr[2];
endmodule

// ----- rtl/core/cvp_check.sv -----
// port-level checks for the camera view block
`timescale 1ns / 1ps
module cvp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] m00,
	input logic [15:0] m11,
	input logic [15:0] m22,
	input logic [31:0] tr_x
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("view word dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(m00) && $stable(tr_x))
		else $error("view word changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready)) else $error("pose ready mismatch");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(m00) <= 16384 && $signed(m00) >= -16384 &&
		$signed(m11) <= 16384 && $signed(m11) >= -16384 &&
		$signed(m22) <= 16384 && $signed(m22) >= -16384))
		else $error("rotation entry out of range");
endmodule

bind camera_view_from_pose cvp_check u_cvp_check (
	.clk(clk), .arst_n(arst_n), .in_ready(pose.ready),
	.out_valid(view.valid), .out_ready(view.ready),
	.m00(view.m00), .m11(view.m11), .m22(view.m22), .tr_x(view.tr_x)
);
